FILE: sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg - shared types and constants for the cartesian to polar converter
// Field widths, item structs, pipeline lane struct and the CORDIC angle table.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int unsigned COORD_WIDTH    = 16;
  localparam int unsigned ANGLE_WIDTH    = 16;
  localparam int unsigned ITERATIONS_DEF = 16;
  localparam int unsigned MAX_ITERATIONS = 32;
  localparam int unsigned CORDIC_FRAC    = 24;
  localparam int unsigned TURN_BITS      = 32;
  // CORDIC datapath: sign, coordinate magnitude, fraction, gain headroom
  localparam int unsigned CW             = COORD_WIDTH + CORDIC_FRAC + 3;
  localparam int unsigned SQ_W           = 2 * COORD_WIDTH;
  localparam int unsigned SQRT_STEPS     = COORD_WIDTH;

  localparam logic [ANGLE_WIDTH-1:0] ANG_ZERO    = '0;
  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 2));
  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = ANGLE_WIDTH'(64'd2 << (ANGLE_WIDTH - 2));
  localparam logic [ANGLE_WIDTH-1:0] ANG_3QUART  = ANGLE_WIDTH'(64'd3 << (ANGLE_WIDTH - 2));
  localparam logic [TURN_BITS-1:0]   ACC_HALF    = {1'b1, {(TURN_BITS - 1){1'b0}}};
  localparam logic [TURN_BITS-1:0]   ACC_ROUND   =
    TURN_BITS'(64'd1 << (TURN_BITS - ANGLE_WIDTH - 1));

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
  } c2p_in_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] magnitude;
    logic [ANGLE_WIDTH-1:0] angle;
  } c2p_out_t;

  typedef struct packed {
    logic                   special;
    logic [ANGLE_WIDTH-1:0] special_angle;
  } c2p_flags_t;

  typedef struct packed {
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic [TURN_BITS-1:0]   acc;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
    c2p_flags_t             flags;
  } c2p_lane_t;

  // atan(2^-i) as a fraction of a turn, 2^32 units per turn
  function automatic logic [TURN_BITS-1:0] c2p_atan(input int unsigned idx);
    logic [TURN_BITS-1:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      24:      v = 32'd41;
      25:      v = 32'd20;
      26:      v = 32'd10;
      27:      v = 32'd5;
      28:      v = 32'd3;
      29:      v = 32'd1;
      30:      v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/c2p_prep.sv
// ----------------------------------------------------------------------------
// c2p_prep - front end of the converter pipeline
// Squares the coordinates, folds the left half plane and flags axis points
// (first register), then sums the squares into the square root radicand.
// ----------------------------------------------------------------------------
module c2p_prep
  import c2p_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  c2p_in_t   in_i,
  output logic      valid_o,
  output c2p_lane_t lane_o
);

  logic signed [COORD_WIDTH-1:0] x, y;
  logic signed [COORD_WIDTH:0]   xe, ye, rx, ry;
  logic [COORD_WIDTH:0]          ax, ay;
  logic [2*COORD_WIDTH+1:0]      px, py;
  logic                          x_neg, y_neg, x_zero, y_zero;
  c2p_flags_t                    flags_d, flags_q;
  logic [SQ_W-1:0]               sq_x_d, sq_x_q, sq_y_d, sq_y_q;
  logic signed [CW-1:0]          cx_d, cx_q, cy_d, cy_q;
  logic [TURN_BITS-1:0]          acc_d, acc_q;
  logic                          valid_a_q, valid_b_q;
  c2p_lane_t                     lane_d, lane_q;

  assign x      = in_i.x_coord;
  assign y      = in_i.y_coord;
  assign x_neg  = x[COORD_WIDTH-1];
  assign y_neg  = y[COORD_WIDTH-1];
  assign x_zero = (x == '0);
  assign y_zero = (y == '0);
  assign xe     = {x[COORD_WIDTH-1], x};
  assign ye     = {y[COORD_WIDTH-1], y};
  assign ax     = x_neg ? -xe : xe;
  assign ay     = y_neg ? -ye : ye;
  assign px     = ax * ax;
  assign py     = ay * ay;
  assign sq_x_d = px[SQ_W-1:0];
  assign sq_y_d = py[SQ_W-1:0];

  // left half plane turned by half a turn
  assign rx    = x_neg ? -xe : xe;
  assign ry    = x_neg ? -ye : ye;
  assign cx_d  = {{(CW - COORD_WIDTH - 1 - CORDIC_FRAC){rx[COORD_WIDTH]}}, rx,
                  {CORDIC_FRAC{1'b0}}};
  assign cy_d  = {{(CW - COORD_WIDTH - 1 - CORDIC_FRAC){ry[COORD_WIDTH]}}, ry,
                  {CORDIC_FRAC{1'b0}}};
  assign acc_d = x_neg ? ACC_HALF : '0;

  always_comb begin
    flags_d.special       = x_zero || y_zero;
    flags_d.special_angle = ANG_ZERO;
    if (y_zero) begin
      flags_d.special_angle = x_neg ? ANG_HALF : ANG_ZERO;
    end else if (x_zero) begin
      flags_d.special_angle = y_neg ? ANG_3QUART : ANG_QUARTER;
    end
  end

  always_comb begin
    lane_d.cx    = cx_q;
    lane_d.cy    = cy_q;
    lane_d.acc   = acc_q;
    lane_d.rem   = sq_x_q + sq_y_q;
    lane_d.root  = '0;
    lane_d.flags = flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_x_q  <= sq_x_d;
    sq_y_q  <= sq_y_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    acc_q   <= acc_d;
    flags_q <= flags_d;
    lane_q  <= lane_d;
  end

  assign valid_o = valid_b_q;
  assign lane_o  = lane_q;

endmodule

FILE: sv/c2p_stage.sv
// ----------------------------------------------------------------------------
// c2p_stage - one register stage of the converter pipeline
// Runs one vectoring CORDIC micro-rotation and one restoring square root
// step side by side; either lane passes through once its steps are done.
// ----------------------------------------------------------------------------
module c2p_stage
  import c2p_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  c2p_lane_t lane_i,
  output logic      valid_o,
  output c2p_lane_t lane_o
);

  logic signed [CW-1:0] cx, cy, cx_n, cy_n;
  logic [TURN_BITS-1:0] acc_n;
  logic [SQ_W-1:0]      rem_n, root_n;
  logic                 valid_q;
  c2p_lane_t            lane_d, lane_q;

  assign cx = lane_i.cx;
  assign cy = lane_i.cy;

  if (IDX < ITERATIONS) begin : g_cordic
    localparam logic [TURN_BITS-1:0] ATAN = c2p_atan(IDX);
    logic signed [CW-1:0] dx, dy;

    assign dx = cy >>> IDX;
    assign dy = cx >>> IDX;

    always_comb begin
      if (!cy[CW-1]) begin
        cx_n  = cx + dx;
        cy_n  = cy - dy;
        acc_n = lane_i.acc + ATAN;
      end else begin
        cx_n  = cx - dx;
        cy_n  = cy + dy;
        acc_n = lane_i.acc - ATAN;
      end
    end
  end else begin : g_cordic_pass
    assign cx_n  = cx;
    assign cy_n  = cy;
    assign acc_n = lane_i.acc;
  end

  if (IDX < SQRT_STEPS) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1 << (2 * (SQRT_STEPS - 1 - IDX)));
    logic [SQ_W:0] trial;
    logic          fits;

    assign trial  = {1'b0, lane_i.root} + {1'b0, BIT};
    assign fits   = {1'b0, lane_i.rem} >= trial;
    assign rem_n  = fits ? (lane_i.rem - trial[SQ_W-1:0]) : lane_i.rem;
    assign root_n = fits ? ((lane_i.root >> 1) + BIT) : (lane_i.root >> 1);
  end else begin : g_sqrt_pass
    assign rem_n  = lane_i.rem;
    assign root_n = lane_i.root;
  end

  always_comb begin
    lane_d      = lane_i;
    lane_d.cx   = cx_n;
    lane_d.cy   = cy_n;
    lane_d.acc  = acc_n;
    lane_d.rem  = rem_n;
    lane_d.root = root_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

FILE: sv/c2p_post.sv
// ----------------------------------------------------------------------------
// c2p_post - back end of the converter pipeline
// Rounds the root to nearest, rounds the turn accumulator to the output
// angle width, substitutes exact angles on the axes and registers the item.
// ----------------------------------------------------------------------------
module c2p_post
  import c2p_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  c2p_lane_t lane_i,
  output logic      done_o,
  output c2p_out_t  res_o
);

  logic                 round_up;
  logic [TURN_BITS-1:0] acc_r;
  logic                 done_q;
  c2p_out_t             res_d, res_q;

  // remainder is sum - r*r; above r means nearer to r+1
  assign round_up = lane_i.rem > lane_i.root;
  assign acc_r    = lane_i.acc + ACC_ROUND;

  always_comb begin
    res_d.magnitude = lane_i.root[COORD_WIDTH-1:0] + COORD_WIDTH'(round_up);
    res_d.angle     = lane_i.flags.special ? lane_i.flags.special_angle
                                           : acc_r[TURN_BITS-1 -: ANGLE_WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: sv/cartesian_to_polar_top.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_top - pipelined cartesian to polar converter
// Gives the rounded length and the angle in turns of a signed 2-D point.
// ----------------------------------------------------------------------------
// Usage:
//   An item (x_coord, y_coord) is taken at each rising edge with start high;
//   busy stays low, so a new item may be offered in every cycle.
//   Each item gives exactly one result on res_o, shown for one cycle with
//   done_o high, in the order the items came in.
//   Throughput: one item per cycle. Pipeline depth is set by the longer of
//   the CORDIC micro-rotation chain and the 16-step square root, one step
//   per stage, plus two front-end stages (squaring, sum) and one output
//   stage.
//   Reset clears the valid bits only; items in flight are dropped and no
//   result comes out for them.
//   The receiver cannot hold results off, so nothing ever stalls inside.
// ----------------------------------------------------------------------------
module cartesian_to_polar_top
  import c2p_pkg::*;
#(
  parameter int unsigned ITERATIONS = ITERATIONS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  c2p_in_t  in_i,
  output logic     done_o,
  output c2p_out_t res_o
);

  localparam int unsigned DEPTH   = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;
  localparam int unsigned LATENCY = DEPTH + 3;

  logic      valid_c [0:DEPTH];
  c2p_lane_t lane_c  [0:DEPTH];

  assign busy = 1'b0;

  c2p_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .in_i    (in_i),
    .valid_o (valid_c[0]),
    .lane_o  (lane_c[0])
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    c2p_stage #(
      .IDX        (k),
      .ITERATIONS (ITERATIONS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .lane_i  (lane_c[k]),
      .valid_o (valid_c[k+1]),
      .lane_o  (lane_c[k+1])
    );
  end

  c2p_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[DEPTH]),
    .lane_i  (lane_c[DEPTH]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && in_i.x_coord == '0 && in_i.y_coord == '0) |-> ##LATENCY
    (done_o && res_o.magnitude == '0 && res_o.angle == '0))
    else $error("origin not mapped to zero length and angle");

  a_positive_x_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && in_i.y_coord == '0 && !in_i.x_coord[COORD_WIDTH-1] && in_i.x_coord != '0)
    |-> ##LATENCY (done_o && res_o.angle == '0 &&
                   res_o.magnitude == $past(in_i.x_coord, LATENCY)))
    else $error("point on positive x axis converted wrongly");
`endif

endmodule
